FILE: sv/smgs_pkg.sv
// Package: shared types, codes and constants of the servo mixer and gear sequencer.
`timescale 1ns / 1ps

package smgs_pkg;

   // Field widths
   localparam int CH_W       = 4;
   localparam int PULSE_W    = 12;
   localparam int STICK_W    = 12;
   localparam int TIME_W     = 32;
   localparam int PVAL_W     = 13;
   localparam int RATE_W     = 8;
   localparam int DIFF_W     = 13;
   localparam int MIX_W      = 14;
   localparam int MUL_W      = 22;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int QUO_W      = 15;
   localparam int SUM_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Divide by 100 as multiply by reciprocal: exact for magnitudes up to 2**20
   localparam logic signed [MUL_W-1:0] RECIP_100   = 22'sd1342178;
   localparam int                      RECIP_SHIFT = 27;

   localparam logic signed [MIX_W-1:0] CUT_THROTTLE = -14'sd500;

   // Reset values
   localparam logic [PULSE_W-1:0]       LIMIT_LOW_RST  = 12'd1000;
   localparam logic [PULSE_W-1:0]       LIMIT_HIGH_RST = 12'd2000;
   localparam logic [PULSE_W-1:0]       CENTER_RST     = 12'd1500;
   localparam logic signed [RATE_W-1:0] RATE_RST       = 8'sd100;
   localparam logic [STICK_W-1:0]       MID_STICK_RST  = 12'd1500;
   localparam logic [TIME_W-1:0]        GEAR_TIME_RST  = 32'd4000000;

   typedef enum logic {
      CMD_MIX,
      CMD_PARAM
   } cmd_type;

   typedef enum logic [1:0] {
      FIELD_MIN,
      FIELD_MAX,
      FIELD_CENTER,
      FIELD_RATE
   } field_type;

   typedef enum logic {
      CSR_MID_STICK,
      CSR_GEAR_TIME
   } csr_index_type;

   typedef enum logic [2:0] {
      GEAR_UNKNOWN,
      GEAR_CLOSED,
      GEAR_OPEN_MAIN,
      GEAR_OPEN_FRONT,
      GEAR_OPENED,
      GEAR_CLOSE_FRONT,
      GEAR_CLOSE_MAIN
   } gear_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_RATE,
      ST_MUL_RECIP,
      ST_FINISH,
      ST_FLUSH
   } seq_state_type;

   // Receiver frame as seen by the mixer
   typedef struct packed {
      logic [STICK_W-1:0] throttle;
      logic [STICK_W-1:0] roll;
      logic [STICK_W-1:0] pitch;
      logic [STICK_W-1:0] yaw;
      logic [STICK_W-1:0] gear_switch;
      logic [STICK_W-1:0] flap;
      logic [TIME_W-1:0]  now_us;
   } frame_type;

   // Limits the mixer needs from the parameter tables
   typedef struct packed {
      logic [PULSE_W-1:0] lo_thr;
      logic [PULSE_W-1:0] hi_thr;
      logic [PULSE_W-1:0] lo_main;
      logic [PULSE_W-1:0] hi_main;
      logic [PULSE_W-1:0] lo_front;
      logic [PULSE_W-1:0] hi_front;
   } limits_type;

   typedef struct packed {
      logic            load;
      logic [CH_W-1:0] sel;
   } mix_ctrl_type;

   typedef struct packed {
      logic                    enable;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

endpackage

FILE: sv/smgs_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps

interface smgs_req_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       command;
   logic [smgs_pkg::STICK_W-1:0]               throttle_in;
   logic [smgs_pkg::STICK_W-1:0]               roll_in;
   logic [smgs_pkg::STICK_W-1:0]               pitch_in;
   logic [smgs_pkg::STICK_W-1:0]               yaw_in;
   logic [smgs_pkg::STICK_W-1:0]               gear_switch_in;
   logic [smgs_pkg::STICK_W-1:0]               flap_in;
   logic [smgs_pkg::TIME_W-1:0]                now_us;
   logic [smgs_pkg::CH_W-1:0]                  param_channel;
   logic [1:0]                                 param_field;
   logic signed [smgs_pkg::PVAL_W-1:0]         param_value;

   modport source (
      output valid, command, throttle_in, roll_in, pitch_in, yaw_in,
             gear_switch_in, flap_in, now_us, param_channel, param_field, param_value,
      input  ready
   );
   modport sink (
      input  valid, command, throttle_in, roll_in, pitch_in, yaw_in,
             gear_switch_in, flap_in, now_us, param_channel, param_field, param_value,
      output ready
   );
endinterface

interface smgs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [smgs_pkg::CH_W-1:0]     channel;
   logic [smgs_pkg::PULSE_W-1:0]  pulse;
   logic                          last;

   modport source (output valid, channel, pulse, last, input ready);
   modport sink   (input valid, channel, pulse, last, output ready);
endinterface

FILE: sv/servo_mixer_gear_sequencer.sv
// Top level: servo mixer with gear sequencer, parameter tables and output sequencing.
//
//   channel   | direction | handshake     | carries
//   ----------+-----------+---------------+-------------------------------------------
//   req_chan  | in        | valid/ready   | frame (six sticks, time) or parameter write
//   rsp_chan  | out       | valid/ready   | channel, pulse, last; one per changed pulse
//   psel/...  | in        | APB setup/acc | mid_stick at 0x0, gear_move_time_us at 0x4
//
// A parameter write is taken in the idle state. A frame is taken there too, with
// a mix and gear sequencer step; then three steps per channel on the shared
// multiplier (rate product, reciprocal of 100, scale/clamp), then a flush step
// releases the last result. A full output register stalls the channel walk.
// Synchronous reset loads every table with its default; there is no clearing pass.
`timescale 1ns / 1ps

module servo_mixer_gear_sequencer #(
   parameter int NUM_CHANNELS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   smgs_req_if.sink                          req_chan,
   smgs_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [smgs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [smgs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [smgs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int IDX_W = $clog2(NUM_CHANNELS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_CHANNELS - 1);
   localparam logic [IDX_W-1:0] MAIN_IDX  = IDX_W'(NUM_CHANNELS - 2);
   localparam logic [IDX_W-1:0] FRONT_IDX = IDX_W'(NUM_CHANNELS - 1);

   // Parameter tables and last pulses
   logic [smgs_pkg::PULSE_W-1:0]       lo_tbl_ff   [NUM_CHANNELS];
   logic [smgs_pkg::PULSE_W-1:0]       hi_tbl_ff   [NUM_CHANNELS];
   logic [smgs_pkg::PULSE_W-1:0]       ctr_tbl_ff  [NUM_CHANNELS];
   logic signed [smgs_pkg::RATE_W-1:0] rate_tbl_ff [NUM_CHANNELS];
   logic [smgs_pkg::PULSE_W-1:0]       prev_ff     [NUM_CHANNELS];

   smgs_pkg::seq_state_type            state_ff, state_in;
   logic [IDX_W-1:0]                   ch_ff;
   logic                               neg_ff;

   logic                               pend_valid_ff;
   logic [smgs_pkg::CH_W-1:0]          pend_ch_ff;
   logic [smgs_pkg::PULSE_W-1:0]       pend_pulse_ff;

   logic                               rsp_valid_ff;
   logic [smgs_pkg::CH_W-1:0]          rsp_ch_ff;
   logic [smgs_pkg::PULSE_W-1:0]       rsp_pulse_ff;
   logic                               rsp_last_ff;

   logic [smgs_pkg::STICK_W-1:0]       mid_stick;
   logic [smgs_pkg::TIME_W-1:0]        gear_move_time_us;

   smgs_pkg::mix_ctrl_type             mix_ctrl;
   smgs_pkg::frame_type                frame;
   smgs_pkg::limits_type               limits;
   smgs_pkg::mul_req_type              mul_req;
   logic signed [smgs_pkg::MIX_W-1:0]  mix_value;
   logic signed [smgs_pkg::PROD_W-1:0] prod;
   logic signed [smgs_pkg::PROD_W-1:0] prod_abs;

   logic                               req_ready;
   logic                               accept, frame_go, param_go;
   logic                               out_free, changed, fin_stall, flush_go;
   logic                               fin_step, fin_push, flush_push;
   logic [smgs_pkg::QUO_W-1:0]         quo;
   logic signed [smgs_pkg::SUM_W-1:0]  quo_s, scaled, sum, lo_s, hi_s;
   logic [smgs_pkg::PULSE_W-1:0]       pulse_new;
   logic [IDX_W-1:0]                   wr_idx;

   assign accept   = req_chan.valid && req_ready;
   assign frame_go = accept && (req_chan.command == smgs_pkg::CMD_MIX);
   assign param_go = accept && (req_chan.command == smgs_pkg::CMD_PARAM)
                     && (req_chan.param_channel < smgs_pkg::CH_W'(NUM_CHANNELS));
   assign wr_idx   = req_chan.param_channel[IDX_W-1:0];

   // Configuration registers
   smgs_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .mid_stick         (mid_stick),
      .gear_move_time_us (gear_move_time_us)
   );

   // Mixer and gear sequencer
   assign frame.throttle    = req_chan.throttle_in;
   assign frame.roll        = req_chan.roll_in;
   assign frame.pitch       = req_chan.pitch_in;
   assign frame.yaw         = req_chan.yaw_in;
   assign frame.gear_switch = req_chan.gear_switch_in;
   assign frame.flap        = req_chan.flap_in;
   assign frame.now_us      = req_chan.now_us;

   assign limits.lo_thr   = lo_tbl_ff[0];
   assign limits.hi_thr   = hi_tbl_ff[0];
   assign limits.lo_main  = lo_tbl_ff[MAIN_IDX];
   assign limits.hi_main  = hi_tbl_ff[MAIN_IDX];
   assign limits.lo_front = lo_tbl_ff[FRONT_IDX];
   assign limits.hi_front = hi_tbl_ff[FRONT_IDX];

   assign mix_ctrl.load = frame_go;
   assign mix_ctrl.sel  = smgs_pkg::CH_W'(ch_ff);

   smgs_mix u_mix (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (mix_ctrl),
      .frame             (frame),
      .mid_stick         (mid_stick),
      .gear_move_time_us (gear_move_time_us),
      .limits            (limits),
      .mix_value         (mix_value)
   );

   // Shared multiplier
   smgs_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (prod)
   );

   // Scale, offset and clamp of the current channel
   assign prod_abs  = prod[smgs_pkg::PROD_W-1] ? -prod : prod;
   assign quo       = prod[smgs_pkg::RECIP_SHIFT +: smgs_pkg::QUO_W];
   assign quo_s     = signed'(smgs_pkg::SUM_W'(quo));
   assign scaled    = neg_ff ? -quo_s : quo_s;
   assign sum       = signed'(smgs_pkg::SUM_W'(ctr_tbl_ff[ch_ff])) + scaled;
   assign lo_s      = signed'(smgs_pkg::SUM_W'(lo_tbl_ff[ch_ff]));
   assign hi_s      = signed'(smgs_pkg::SUM_W'(hi_tbl_ff[ch_ff]));

   always_comb begin
      if (sum < lo_s) begin
         pulse_new = lo_tbl_ff[ch_ff];
      end else if (sum > hi_s) begin
         pulse_new = hi_tbl_ff[ch_ff];
      end else begin
         pulse_new = sum[smgs_pkg::PULSE_W-1:0];
      end
   end

   assign changed   = pulse_new != prev_ff[ch_ff];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign fin_stall = changed && pend_valid_ff && !out_free;
   assign flush_go  = !pend_valid_ff || out_free;

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smgs_pkg::ST_IDLE:      if (frame_go) state_in = smgs_pkg::ST_MUL_RATE;
         smgs_pkg::ST_MUL_RATE:  state_in = smgs_pkg::ST_MUL_RECIP;
         smgs_pkg::ST_MUL_RECIP: state_in = smgs_pkg::ST_FINISH;
         smgs_pkg::ST_FINISH: begin
            if (!fin_stall) begin
               state_in = (ch_ff == LAST_IDX) ? smgs_pkg::ST_FLUSH : smgs_pkg::ST_MUL_RATE;
            end
         end
         smgs_pkg::ST_FLUSH:     if (flush_go) state_in = smgs_pkg::ST_IDLE;
         default:                state_in = smgs_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_ready      = 1'b0;
      mul_req.enable = 1'b0;
      mul_req.a      = '0;
      mul_req.b      = '0;
      fin_step       = 1'b0;
      flush_push     = 1'b0;
      case (state_ff)
         smgs_pkg::ST_IDLE: req_ready = 1'b1;
         smgs_pkg::ST_MUL_RATE: begin
            mul_req.enable = 1'b1;
            mul_req.a      = smgs_pkg::MUL_W'(rate_tbl_ff[ch_ff]);
            mul_req.b      = smgs_pkg::MUL_W'(mix_value);
         end
         smgs_pkg::ST_MUL_RECIP: begin
            mul_req.enable = 1'b1;
            mul_req.a      = prod_abs[smgs_pkg::MUL_W-1:0];
            mul_req.b      = smgs_pkg::RECIP_100;
         end
         smgs_pkg::ST_FINISH: fin_step = !fin_stall;
         smgs_pkg::ST_FLUSH:  flush_push = pend_valid_ff && out_free;
         default: ;
      endcase
   end

   assign fin_push = fin_step && changed && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smgs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Channel index and product sign
   always_ff @(posedge clock) begin
      if (frame_go) begin
         ch_ff <= '0;
      end else if (fin_step) begin
         ch_ff <= ch_ff + 1'b1;
      end
      if (state_ff == smgs_pkg::ST_MUL_RECIP) begin
         neg_ff <= prod[smgs_pkg::PROD_W-1];
      end
   end

   // Parameter tables and last pulses
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            lo_tbl_ff[i]   <= smgs_pkg::LIMIT_LOW_RST;
            hi_tbl_ff[i]   <= smgs_pkg::LIMIT_HIGH_RST;
            ctr_tbl_ff[i]  <= smgs_pkg::CENTER_RST;
            rate_tbl_ff[i] <= smgs_pkg::RATE_RST;
            prev_ff[i]     <= '0;
         end
      end else begin
         if (param_go) begin
            case (smgs_pkg::field_type'(req_chan.param_field))
               smgs_pkg::FIELD_MIN:
                  lo_tbl_ff[wr_idx] <= req_chan.param_value[smgs_pkg::PULSE_W-1:0];
               smgs_pkg::FIELD_MAX:
                  hi_tbl_ff[wr_idx] <= req_chan.param_value[smgs_pkg::PULSE_W-1:0];
               smgs_pkg::FIELD_CENTER:
                  ctr_tbl_ff[wr_idx] <= req_chan.param_value[smgs_pkg::PULSE_W-1:0];
               smgs_pkg::FIELD_RATE:
                  rate_tbl_ff[wr_idx] <= signed'(req_chan.param_value[smgs_pkg::RATE_W-1:0]);
               default: ;
            endcase
         end
         if (fin_step && changed) begin
            prev_ff[ch_ff] <= pulse_new;
         end
      end
   end

   // Pending result: held back until we know whether it is the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (fin_step && changed) begin
         pend_valid_ff <= 1'b1;
      end else if (flush_push) begin
         pend_valid_ff <= 1'b0;
      end
      if (fin_step && changed) begin
         pend_ch_ff    <= smgs_pkg::CH_W'(ch_ff);
         pend_pulse_ff <= pulse_new;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_push || flush_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fin_push || flush_push) begin
         rsp_ch_ff    <= pend_ch_ff;
         rsp_pulse_ff <= pend_pulse_ff;
         rsp_last_ff  <= flush_push;
      end
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.channel = rsp_ch_ff;
   assign rsp_chan.pulse   = rsp_pulse_ff;
   assign rsp_chan.last    = rsp_last_ff;

endmodule

FILE: sv/smgs_csr.sv
// Module: APB-style configuration registers (stick center, gear move time).
`timescale 1ns / 1ps

module smgs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [smgs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [smgs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [smgs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [smgs_pkg::STICK_W-1:0]      mid_stick,
   output logic [smgs_pkg::TIME_W-1:0]       gear_move_time_us
);

   logic [smgs_pkg::STICK_W-1:0] mid_stick_ff;
   logic [smgs_pkg::STICK_W-1:0] mid_stick_in;
   logic [smgs_pkg::TIME_W-1:0]  gear_time_ff;
   logic [smgs_pkg::TIME_W-1:0]  gear_time_in;
   logic                         wr_en;
   smgs_pkg::csr_index_type      reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = smgs_pkg::csr_index_type'(paddr[2]);

   // Register write decode
   always_comb begin
      mid_stick_in = mid_stick_ff;
      gear_time_in = gear_time_ff;
      if (wr_en) begin
         case (reg_idx)
            smgs_pkg::CSR_MID_STICK: mid_stick_in = pwdata[smgs_pkg::STICK_W-1:0];
            smgs_pkg::CSR_GEAR_TIME: gear_time_in = pwdata[smgs_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_stick_ff <= smgs_pkg::MID_STICK_RST;
         gear_time_ff <= smgs_pkg::GEAR_TIME_RST;
      end else begin
         mid_stick_ff <= mid_stick_in;
         gear_time_ff <= gear_time_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         smgs_pkg::CSR_MID_STICK: prdata = smgs_pkg::CSR_DATA_W'(mid_stick_ff);
         smgs_pkg::CSR_GEAR_TIME: prdata = gear_time_ff;
         default:                 prdata = '0;
      endcase
   end

   assign mid_stick         = mid_stick_ff;
   assign gear_move_time_us = gear_time_ff;

endmodule

FILE: sv/smgs_mul.sv
// Module: shared signed multiplier with registered product.
`timescale 1ns / 1ps

module smgs_mul (
   input  logic                                clock,
   input  smgs_pkg::mul_req_type               req,
   output logic signed [smgs_pkg::PROD_W-1:0]  prod
);

   logic signed [smgs_pkg::PROD_W-1:0] prod_ff;

   // Product held until the next enabled operation
   always_ff @(posedge clock) begin
      if (req.enable) begin
         prod_ff <= req.a * req.b;
      end
   end

   assign prod = prod_ff;

endmodule

FILE: sv/smgs_mix.sv
// Module: frame mixing (V-tail, airbrake, flaps, throttle) and gear sequencer.
`timescale 1ns / 1ps

module smgs_mix (
   input  logic                               clock,
   input  logic                               reset,
   input  smgs_pkg::mix_ctrl_type             ctrl,
   input  smgs_pkg::frame_type                frame,
   input  logic [smgs_pkg::STICK_W-1:0]       mid_stick,
   input  logic [smgs_pkg::TIME_W-1:0]        gear_move_time_us,
   input  smgs_pkg::limits_type               limits,
   output logic signed [smgs_pkg::MIX_W-1:0]  mix_value
);

   localparam int NUM_MIX = 10;

   logic signed [smgs_pkg::DIFF_W-1:0] mid_s;
   logic signed [smgs_pkg::DIFF_W-1:0] thro_d, roll_d, pitch_d, yaw_d, flap_d;
   logic signed [smgs_pkg::DIFF_W-1:0] quarter, brake, span;
   logic signed [smgs_pkg::DIFF_W-1:0] gmn, gmx, gfn, gfx;
   logic signed [smgs_pkg::MIX_W-1:0]  thr_offs;
   logic signed [smgs_pkg::MIX_W-1:0]  mix_in [NUM_MIX];
   logic signed [smgs_pkg::MIX_W-1:0]  mix_ff [NUM_MIX];
   logic                               down, moving;
   logic                               main_open, front_open;

   smgs_pkg::gear_phase_type           phase_ff, phase_in;
   logic [smgs_pkg::TIME_W-1:0]        start_ff, start_in;

   // Channels relative to stick center
   assign mid_s   = signed'({1'b0, mid_stick});
   assign thro_d  = signed'({1'b0, frame.throttle}) - mid_s;
   assign roll_d  = signed'({1'b0, frame.roll}) - mid_s;
   assign pitch_d = signed'({1'b0, frame.pitch}) - mid_s;
   assign yaw_d   = signed'({1'b0, frame.yaw}) - mid_s;
   assign flap_d  = signed'({1'b0, frame.flap}) - mid_s;
   assign down    = frame.gear_switch < mid_stick;

   // Floor shifts
   assign quarter  = yaw_d >>> 2;
   assign brake    = thro_d >>> 1;
   assign span     = signed'({1'b0, limits.hi_thr}) - signed'({1'b0, limits.lo_thr});
   assign thr_offs = smgs_pkg::MIX_W'(span >>> 2) <<< 1;

   // Gear end points
   assign gmn = signed'({1'b0, limits.lo_main}) - mid_s;
   assign gmx = signed'({1'b0, limits.hi_main}) - mid_s;
   assign gfn = signed'({1'b0, limits.lo_front}) - mid_s;
   assign gfx = signed'({1'b0, limits.hi_front}) - mid_s;

   assign moving = (frame.now_us - start_ff) < gear_move_time_us;

   // Gear sequencer: next phase
   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      if (down) begin
         case (phase_ff)
            smgs_pkg::GEAR_CLOSED: ;
            smgs_pkg::GEAR_OPEN_MAIN, smgs_pkg::GEAR_CLOSE_FRONT: begin
               if (!moving) begin
                  phase_in = smgs_pkg::GEAR_CLOSE_MAIN;
                  start_in = frame.now_us;
               end
            end
            smgs_pkg::GEAR_OPEN_FRONT: begin
               if (!moving) begin
                  phase_in = smgs_pkg::GEAR_CLOSE_FRONT;
                  start_in = frame.now_us;
               end
            end
            smgs_pkg::GEAR_OPENED: begin
               phase_in = smgs_pkg::GEAR_CLOSE_FRONT;
               start_in = frame.now_us;
            end
            smgs_pkg::GEAR_CLOSE_MAIN: begin
               if (!moving) phase_in = smgs_pkg::GEAR_CLOSED;
            end
            default: phase_in = smgs_pkg::GEAR_CLOSED;
         endcase
      end else begin
         case (phase_ff)
            smgs_pkg::GEAR_CLOSED: begin
               phase_in = smgs_pkg::GEAR_OPEN_MAIN;
               start_in = frame.now_us;
            end
            smgs_pkg::GEAR_OPEN_MAIN, smgs_pkg::GEAR_CLOSE_FRONT: begin
               if (!moving) begin
                  phase_in = smgs_pkg::GEAR_OPEN_FRONT;
                  start_in = frame.now_us;
               end
            end
            smgs_pkg::GEAR_OPEN_FRONT: begin
               if (!moving) phase_in = smgs_pkg::GEAR_OPENED;
            end
            smgs_pkg::GEAR_OPENED: ;
            smgs_pkg::GEAR_CLOSE_MAIN: begin
               if (!moving) begin
                  phase_in = smgs_pkg::GEAR_OPEN_MAIN;
                  start_in = frame.now_us;
               end
            end
            default: phase_in = smgs_pkg::GEAR_OPENED;
         endcase
      end
   end

   // Gear sequencer: servo positions (1 = open end)
   always_comb begin
      main_open  = 1'b0;
      front_open = 1'b0;
      if (down) begin
         case (phase_ff)
            smgs_pkg::GEAR_OPEN_MAIN, smgs_pkg::GEAR_CLOSE_FRONT: main_open = moving;
            smgs_pkg::GEAR_OPEN_FRONT: begin
               main_open  = 1'b1;
               front_open = moving;
            end
            smgs_pkg::GEAR_OPENED: main_open = 1'b1;
            default: ;
         endcase
      end else begin
         case (phase_ff)
            smgs_pkg::GEAR_CLOSED: main_open = 1'b1;
            smgs_pkg::GEAR_OPEN_MAIN, smgs_pkg::GEAR_CLOSE_FRONT: begin
               main_open  = 1'b1;
               front_open = !moving;
            end
            smgs_pkg::GEAR_CLOSE_MAIN: main_open = !moving;
            default: begin
               main_open  = 1'b1;
               front_open = 1'b1;
            end
         endcase
      end
   end

   // Mixed channel values
   always_comb begin
      mix_in[1] = -smgs_pkg::MIX_W'(pitch_d) - smgs_pkg::MIX_W'(quarter);
      mix_in[2] = smgs_pkg::MIX_W'(pitch_d) - smgs_pkg::MIX_W'(quarter);
      mix_in[3] = smgs_pkg::MIX_W'(yaw_d);
      mix_in[5] = smgs_pkg::MIX_W'(flap_d);
      mix_in[6] = -smgs_pkg::MIX_W'(flap_d);
      if (thro_d >= 0) begin
         mix_in[0] = smgs_pkg::MIX_W'(thro_d) - thr_offs;
         mix_in[4] = smgs_pkg::MIX_W'(roll_d);
         mix_in[7] = smgs_pkg::MIX_W'(roll_d);
      end else begin
         mix_in[0] = smgs_pkg::CUT_THROTTLE;
         mix_in[4] = smgs_pkg::MIX_W'(roll_d) - smgs_pkg::MIX_W'(brake);
         mix_in[7] = smgs_pkg::MIX_W'(roll_d) + smgs_pkg::MIX_W'(brake);
      end
      mix_in[8] = main_open  ? smgs_pkg::MIX_W'(gmx) : smgs_pkg::MIX_W'(gmn);
      mix_in[9] = front_open ? smgs_pkg::MIX_W'(gfx) : smgs_pkg::MIX_W'(gfn);
   end

   // Frame results, no reset needed
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         for (int i = 0; i < NUM_MIX; i++) begin
            mix_ff[i] <= mix_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= smgs_pkg::GEAR_UNKNOWN;
         start_ff <= '0;
      end else if (ctrl.load) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
      end
   end

   assign mix_value = mix_ff[ctrl.sel];

endmodule
